>>> design/dsfa_pkg.sv
// dsfa_pkg: shared types, codes and constants for the dust sensor frame accumulator
// no dependencies; imported by every module of the block

package dsfa_pkg;

  // default configuration of the top level
  localparam int FRAME_BYTES_DEF = 24;
  localparam int SUM_WIDTH_DEF   = 32;

  // fixed widths of state and result fields
  localparam int POS_W      = 5;
  localparam int CSUM_W     = 16;
  localparam int READING_W  = 16;
  localparam int CNT_W      = 32;
  localparam int OUT_SUM_W  = 32;
  localparam int NUM_PM     = 3;

  // frame layout
  localparam logic [7:0] HDR0      = 8'h42;
  localparam logic [7:0] HDR1      = 8'h4D;
  localparam int         CAP_FIRST = 4;
  localparam int         CAP_COUNT = 2 * NUM_PM;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CSUM = 2'd1,
    ST_HDR  = 2'd2
  } status_t;

  // one received byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } byte_item_t;

  // one completed frame as classified by the front
  typedef struct packed {
    logic                                csum_ok;
    logic                                hdr_ok;
    logic [NUM_PM-1:0][READING_W-1:0]    reading;
  } frame_rec_t;

  // one result
  typedef struct packed {
    status_t               status;
    logic [READING_W-1:0]  pm1_value;
    logic [READING_W-1:0]  pm25_value;
    logic [READING_W-1:0]  pm10_value;
    logic [OUT_SUM_W-1:0]  pm1_total;
    logic [OUT_SUM_W-1:0]  pm25_total;
    logic [OUT_SUM_W-1:0]  pm10_total;
    logic [CNT_W-1:0]      frames_accepted;
  } frame_result_t;

endpackage

>>> design/dsfa_front.sv
// dsfa_front: byte parser; tracks position, checksum, header and captured readings
// depends on dsfa_pkg; pushes one record per completed frame into dsfa_queue

module dsfa_front #(
  parameter int FRAME_BYTES = dsfa_pkg::FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dsfa_pkg::byte_item_t  byte_item,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  output logic                  push,
  output dsfa_pkg::frame_rec_t  push_data,
  input  logic                  full
);
  import dsfa_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS      = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] CHK_HI_POS    = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] CSUM_LAST_POS = POS_W'(FRAME_BYTES - 3);

  logic [POS_W-1:0]  byte_position;
  logic [CSUM_W-1:0] running_checksum;
  logic              header_ok;
  logic [7:0]        cap [CAP_COUNT];
  logic [7:0]        chk_hi;

  logic              accept;
  logic [POS_W-1:0]  pos;
  logic [CSUM_W-1:0] csum_base;
  logic [CSUM_W-1:0] csum_next;
  logic              hdr_next;

  // request is taken whenever the queue has room
  assign byte_stall = full;
  assign accept     = byte_valid && !full;

  // position of this byte and the per-frame state it builds on
  always_comb begin
    pos       = byte_item.restart ? '0 : byte_position;
    csum_base = (pos == '0) ? '0 : running_checksum;
    csum_next = (pos <= CSUM_LAST_POS) ? csum_base + CSUM_W'(byte_item.rx_byte) : csum_base;
    hdr_next  = (pos == '0) ? 1'b1 : header_ok;
    if (pos == POS_W'(0) && byte_item.rx_byte != HDR0) begin
      hdr_next = 1'b0;
    end
    if (pos == POS_W'(1) && byte_item.rx_byte != HDR1) begin
      hdr_next = 1'b0;
    end
  end

  // frame record on the last byte
  always_comb begin
    push              = accept && (pos == LAST_POS);
    push_data.csum_ok = (csum_base == {chk_hi, byte_item.rx_byte});
    push_data.hdr_ok  = hdr_next;
    for (int k = 0; k < NUM_PM; k++) begin
      push_data.reading[k] = {cap[2*k], cap[2*k+1]};
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      running_checksum <= '0;
      header_ok        <= 1'b1;
    end else if (accept) begin
      byte_position    <= (pos == LAST_POS) ? '0 : pos + POS_W'(1);
      running_checksum <= csum_next;
      header_ok        <= hdr_next;
    end
  end

  // captured reading bytes and checksum high byte
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < CAP_COUNT; i++) begin
        if (pos == POS_W'(CAP_FIRST + i)) begin
          cap[i] <= byte_item.rx_byte;
        end
      end
      if (pos == CHK_HI_POS) begin
        chk_hi <= byte_item.rx_byte;
      end
    end
  end

endmodule

>>> design/dsfa_queue.sv
// dsfa_queue: short register queue of frame records between front and back
// depends on dsfa_pkg

module dsfa_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dsfa_pkg::frame_rec_t  push_data,
  output logic                  full,
  input  logic                  pop,
  output dsfa_pkg::frame_rec_t  pop_data,
  output logic                  empty
);
  import dsfa_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W_Q-1:0] DEPTH_CNT = CNT_W_Q'(QUEUE_DEPTH);

  frame_rec_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W_Q-1:0]   count;

  assign full     = (count == DEPTH_CNT);
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W_Q'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W_Q'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_CNT)
    else $error("queue count out of range");
`endif

endmodule

>>> design/dsfa_back.sv
// dsfa_back: pops frame records, updates saturating totals, holds the result register
// depends on dsfa_pkg; fed by dsfa_queue

module dsfa_back #(
  parameter int SUM_WIDTH = dsfa_pkg::SUM_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dsfa_pkg::frame_rec_t     pop_data,
  input  logic                     empty,
  output logic                     pop,
  output dsfa_pkg::frame_result_t  frame_result,
  output logic                     frame_valid,
  input  logic                     frame_stall
);
  import dsfa_pkg::*;

  logic [SUM_WIDTH-1:0]           sums [NUM_PM];
  logic [CNT_W-1:0]               frame_counter;

  logic                           good;
  status_t                        status;
  logic [SUM_WIDTH:0]             raw [NUM_PM];
  logic [SUM_WIDTH-1:0]           sum_next [NUM_PM];
  logic [SUM_WIDTH+OUT_SUM_W-1:0] sum_ext [NUM_PM];
  logic [CNT_W-1:0]               count_next;

  // take a record when the result register is free or being drained
  assign pop  = !empty && (!frame_valid || !frame_stall);
  assign good = pop_data.csum_ok && pop_data.hdr_ok;

  // status: checksum first, then header
  always_comb begin
    priority if (!pop_data.csum_ok) begin
      status = ST_CSUM;
    end else if (!pop_data.hdr_ok) begin
      status = ST_HDR;
    end else begin
      status = ST_OK;
    end
  end

  // saturating totals
  always_comb begin
    for (int k = 0; k < NUM_PM; k++) begin
      raw[k]      = {1'b0, sums[k]} + (SUM_WIDTH+1)'(pop_data.reading[k]);
      sum_next[k] = !good ? sums[k] : (raw[k][SUM_WIDTH] ? '1 : raw[k][SUM_WIDTH-1:0]);
      sum_ext[k]  = {{OUT_SUM_W{1'b0}}, sum_next[k]};
    end
    count_next = (good && frame_counter != '1) ? frame_counter + CNT_W'(1) : frame_counter;
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_PM; k++) begin
        sums[k] <= '0;
      end
      frame_counter <= '0;
    end else if (pop) begin
      for (int k = 0; k < NUM_PM; k++) begin
        sums[k] <= sum_next[k];
      end
      frame_counter <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (pop) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame_result.status          <= status;
      frame_result.pm1_value       <= pop_data.reading[0];
      frame_result.pm25_value      <= pop_data.reading[1];
      frame_result.pm10_value      <= pop_data.reading[2];
      frame_result.pm1_total       <= sum_ext[0][OUT_SUM_W-1:0];
      frame_result.pm25_total      <= sum_ext[1][OUT_SUM_W-1:0];
      frame_result.pm10_total      <= sum_ext[2][OUT_SUM_W-1:0];
      frame_result.frames_accepted <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_step: assert property (@(posedge clk) disable iff (rst)
      pop && good && frame_counter != '1 |=> frame_counter == $past(frame_counter) + CNT_W'(1))
    else $error("accepted frame did not advance the count");
  a_pop_shows: assert property (@(posedge clk) disable iff (rst) pop |=> frame_valid)
    else $error("popped record not presented");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
      frame_valid && frame_stall |=> frame_valid && $stable(frame_result))
    else $error("stalled result changed");
`endif

endmodule

>>> design/dust_sensor_frame_accumulator_core.sv
// dust_sensor_frame_accumulator_core: top level of the particulate sensor frame accumulator
// depends on dsfa_pkg, dsfa_front, dsfa_queue, dsfa_back
//
//   channel   direction  payload          handshake
//   byte      in         byte_item_t      byte_valid / byte_stall
//   frame     out        frame_result_t   frame_valid / frame_stall
//
// one byte per cycle accepted while the queue is not full; after its last byte is accepted,
// a frame's record is registered in the record queue and then in the result register.
// totals saturate in a single add-and-compare stage in the back end.
// rst is synchronous; clears position, checksum, totals and the queue, and sets the header flag.
// byte_stall rises only while the queue is full; frame_stall holds the result
// register and, once the queue fills, the byte side.

module dust_sensor_frame_accumulator_core #(
  parameter int FRAME_BYTES = dsfa_pkg::FRAME_BYTES_DEF,
  parameter int SUM_WIDTH   = dsfa_pkg::SUM_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dsfa_pkg::byte_item_t     byte_item,
  input  logic                     byte_valid,
  output logic                     byte_stall,
  output dsfa_pkg::frame_result_t  frame_result,
  output logic                     frame_valid,
  input  logic                     frame_stall
);
  import dsfa_pkg::*;

  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  frame_rec_t push_data;
  frame_rec_t pop_data;

  // byte parser
  dsfa_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_item  (byte_item),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .push       (push),
    .push_data  (push_data),
    .full       (full)
  );

  // record queue
  dsfa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // accumulator and result register
  dsfa_back #(.SUM_WIDTH(SUM_WIDTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_data     (pop_data),
    .empty        (empty),
    .pop          (pop),
    .frame_result (frame_result),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall)
  );

endmodule

>>> bench/testbench.sv
// testbench for dust_sensor_frame_accumulator_core: drives sensor bytes, predicts frame results
// depends on dsfa_pkg and the design sources; needs no files or arguments at run time

`timescale 1ns / 1ps

module testbench;
  import dsfa_pkg::*;

  localparam int FRAME_LEN    = FRAME_BYTES_DEF;
  localparam int RANDOM_BYTES = 1200;
  localparam int CYCLE_LIMIT  = 150000;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 10;

  // one frame of stimulus: header, readings, checksum damage, restart and truncation
  typedef struct {
    logic [7:0]    h0;
    logic [7:0]    h1;
    logic [15:0]   pm1;
    logic [15:0]   pm25;
    logic [15:0]   pm10;
    logic [15:0]   csum_flip;
    logic          lead_restart;
    int            cut;
    logic [7:0]    fill;
    bit            fill_random;
    bit            typed;
    frame_result_t want;
  } frame_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  byte_item_t    byte_item = '0;
  logic          byte_valid = 1'b0;
  logic          byte_stall;
  frame_result_t frame_result;
  logic          frame_valid;
  logic          frame_stall = 1'b0;

  // predictor state
  logic [4:0]    frame_pos = '0;
  logic [15:0]   frame_csum = '0;
  logic          frame_hdr_ok = 1'b1;
  logic [7:0]    frame_cap [8] = '{default: 8'h00};
  logic [31:0]   pm_totals [3] = '{default: 32'h0};
  logic [31:0]   accepted_count = '0;

  frame_result_t expected_frames [$];
  frame_result_t typed_want = '0;
  logic          typed_armed = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int bytes_sent = 0;
  int mismatches = 0;
  int cycles = 0;

  string field_label [8] = '{"status", "pm1_value", "pm25_value", "pm10_value",
                             "pm1_total", "pm25_total", "pm10_total", "frames_accepted"};

  // columns: h0, h1, pm1, pm25, pm10, csum_flip, lead_restart, cut, fill, fill_random,
  //          typed, want
  frame_row_t directed_frames [11] = '{
    // all readings at maximum, first frame after reset
    '{HDR0, HDR1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 0, 8'h00, 1'b0, 1'b1,
      '{ST_OK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF,
        32'd1}},
    // checksum wrong and header wrong: checksum wins
    '{8'h00, 8'h00, 16'h1234, 16'h5678, 16'h9ABC, 16'h0101, 1'b1, 0, 8'h00, 1'b0, 1'b1,
      '{ST_CSUM, 16'h1234, 16'h5678, 16'h9ABC, 32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF,
        32'd1}},
    // second header byte wrong, checksum good: frame reported with header status, not counted
    '{HDR0, 8'h4C, 16'h0001, 16'h0080, 16'h8000, 16'h0000, 1'b1, 0, 8'hA5, 1'b0, 1'b1,
      '{ST_HDR, 16'h0001, 16'h0080, 16'h8000, 32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF,
        32'd1}},
    // first header byte wrong
    '{8'h43, HDR1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 0, 8'h5A, 1'b0, 1'b0, '0},
    // zero readings, all-ones filler
    '{HDR0, HDR1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 0, 8'hFF, 1'b0, 1'b0, '0},
    // abandoned after ten bytes, next frame restarts
    '{HDR0, HDR1, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h0000, 1'b1, 10, 8'h11, 1'b0, 1'b0, '0},
    '{HDR0, HDR1, 16'h0102, 16'h0304, 16'h0506, 16'h0000, 1'b1, 0, 8'h22, 1'b0, 1'b0, '0},
    // follows a complete frame with no restart: position wraps
    '{HDR0, HDR1, 16'h7FFF, 16'h8000, 16'hFFFE, 16'h0000, 1'b0, 0, 8'h33, 1'b0, 1'b0, '0},
    // checksum wrong, header good
    '{HDR0, HDR1, 16'h00FF, 16'hFF00, 16'h0F0F, 16'h8000, 1'b1, 0, 8'h00, 1'b0, 1'b0, '0},
    // abandoned one byte short of the end
    '{HDR0, HDR1, 16'h4242, 16'h4D4D, 16'h0000, 16'h0000, 1'b1, 23, 8'h77, 1'b0, 1'b0, '0},
    '{HDR0, HDR1, 16'hC3C3, 16'h3C3C, 16'h0001, 16'h0000, 1'b1, 0, 8'h00, 1'b1, 1'b0, '0}
  };

  dust_sensor_frame_accumulator_core DUT (
    .clk          (clk),
    .rst          (rst),
    .byte_item    (byte_item),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .frame_result (frame_result),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // advance the frame parser by one byte; returns 1 when the byte completes a frame
  function automatic bit parse_byte(input byte_item_t it, output frame_result_t res);
    logic [4:0]  slot;
    logic [15:0] reading [3];
    logic [32:0] wide;
    res = '0;
    if (it.restart) frame_pos = '0;
    slot = frame_pos;
    if (slot == 0) begin
      frame_csum = '0;
      frame_hdr_ok = 1'b1;
    end
    if (slot == 0 && it.rx_byte != HDR0) frame_hdr_ok = 1'b0;
    if (slot == 1 && it.rx_byte != HDR1) frame_hdr_ok = 1'b0;
    if (slot >= CAP_FIRST && slot < CAP_FIRST + CAP_COUNT)
      frame_cap[slot - CAP_FIRST] = it.rx_byte;
    if (slot == FRAME_LEN - 2) frame_cap[6] = it.rx_byte;
    if (slot <= FRAME_LEN - 3) frame_csum = frame_csum + it.rx_byte;
    if (slot != FRAME_LEN - 1) begin
      frame_pos = slot + 5'd1;
      return 1'b0;
    end

    // frame complete: classify and accumulate
    frame_pos = '0;
    for (int k = 0; k < NUM_PM; k++) reading[k] = {frame_cap[2 * k], frame_cap[2 * k + 1]};
    if (frame_csum != {frame_cap[6], it.rx_byte}) begin
      res.status = ST_CSUM;
    end else if (!frame_hdr_ok) begin
      res.status = ST_HDR;
    end else begin
      res.status = ST_OK;
      for (int k = 0; k < NUM_PM; k++) begin
        wide = {1'b0, pm_totals[k]} + reading[k];
        pm_totals[k] = wide[32] ? '1 : wide[31:0];
      end
      if (accepted_count != '1) accepted_count = accepted_count + 32'd1;
    end
    res.pm1_value       = reading[0];
    res.pm25_value      = reading[1];
    res.pm10_value      = reading[2];
    res.pm1_total       = pm_totals[0];
    res.pm25_total      = pm_totals[1];
    res.pm10_total      = pm_totals[2];
    res.frames_accepted = accepted_count;
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_reading();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // offer one request, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic r);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_item  <= '{rx_byte: b, restart: r};
    byte_valid <= 1'b1;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // build the frame bytes with checksum, then send all or the first cut of them
  task automatic send_frame(input frame_row_t r);
    logic [7:0]  fb [24];
    logic [15:0] sum;
    int          n;
    sum = '0;
    for (int i = 0; i < FRAME_LEN; i++) fb[i] = r.fill_random ? 8'($urandom) : r.fill;
    fb[0] = r.h0;
    fb[1] = r.h1;
    {fb[4], fb[5], fb[6], fb[7], fb[8], fb[9]} = {r.pm1, r.pm25, r.pm10};
    for (int i = 0; i <= FRAME_LEN - 3; i++) sum = sum + fb[i];
    {fb[FRAME_LEN - 2], fb[FRAME_LEN - 1]} = sum ^ r.csum_flip;
    n = (r.cut != 0) ? r.cut : FRAME_LEN;
    if (r.typed) begin
      typed_want  <= r.want;
      typed_armed <= 1'b1;
    end
    for (int i = 0; i < n; i++) send_byte(fb[i], (i == 0) ? r.lead_restart : 1'b0);
  endtask

  // advance past the current edge first so the last accepted request is already predicted
  task automatic wait_for_results();
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      frame_stall <= 1'b1;
    end else begin
      frame_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // predict on accepted requests, check accepted results
  always @(posedge clk) begin : monitor
    frame_result_t want;
    frame_result_t predicted;
    logic [31:0]   wf [8];
    logic [31:0]   gf [8];
    if (!rst) begin
      if (frame_valid && !frame_stall) begin
        if (expected_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with nothing expected: %h", $time, frame_result);
        end else begin
          want = expected_frames.pop_front();
          wf = '{want.status, want.pm1_value, want.pm25_value, want.pm10_value,
                 want.pm1_total, want.pm25_total, want.pm10_total, want.frames_accepted};
          gf = '{frame_result.status, frame_result.pm1_value, frame_result.pm25_value,
                 frame_result.pm10_value, frame_result.pm1_total, frame_result.pm25_total,
                 frame_result.pm10_total, frame_result.frames_accepted};
          for (int i = 0; i < 8; i++) begin
            if (wf[i] !== gf[i]) begin
              mismatches++;
              if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %h, got %h", $time, field_label[i], wf[i], gf[i]);
            end
          end
        end
      end
      if (byte_valid && !byte_stall) begin
        if (parse_byte(byte_item, predicted)) begin
          if (typed_armed) begin
            expected_frames.push_back(typed_want);
            typed_armed = 1'b0;
          end else begin
            expected_frames.push_back(predicted);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    frame_row_t r;
    int         n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames
    send_idle_pct  = 19;
    recv_stall_pct = 19;
    foreach (directed_frames[i]) send_frame(directed_frames[i]);
    byte_valid <= 1'b0;
    wait_for_results();

    // random traffic in four idling phases, draining between them
    bytes_sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      // long receiver hold-off while bytes keep coming, so the block backs up
      if (ph == 0) hold_left <= HOLD_CYCLES;
      while (bytes_sent < (ph + 1) * RANDOM_BYTES / 4) begin
        if ($urandom_range(99) < 10) begin
          // line noise with occasional restarts
          n = $urandom_range(1, 30);
          for (int i = 0; i < n; i++) send_byte(8'($urandom), ($urandom_range(7) == 0));
        end else begin
          r.h0           = ($urandom_range(99) < 8) ? 8'($urandom) : HDR0;
          r.h1           = ($urandom_range(99) < 8) ? 8'($urandom) : HDR1;
          r.pm1          = pick_reading();
          r.pm25         = pick_reading();
          r.pm10         = pick_reading();
          r.csum_flip    = ($urandom_range(99) < 10) ? 16'($urandom_range(1, 65535)) : 16'h0;
          r.lead_restart = ($urandom_range(99) < 75);
          r.cut          = ($urandom_range(99) < 8) ? $urandom_range(1, FRAME_LEN - 1) : 0;
          r.fill         = 8'h00;
          r.fill_random  = 1'b1;
          r.typed        = 1'b0;
          r.want         = '0;
          send_frame(r);
        end
      end
      byte_valid <= 1'b0;
      wait_for_results();
    end

    // let any stray result show up
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
